// ===== rtl/core/apja_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apja_pkg
// Shared types, constants and step functions of the pose-to-joint-angle block.
// ----------------------------------------------------------------------------
package apja_pkg;

   // Field widths
   localparam int COORD_W   = 20;
   localparam int ANG_W     = 20;
   localparam int REACH_W   = 19;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 20;

   // Iteration counts of the unrolled units
   localparam int CORDIC_STEPS = 24;
   localparam int SQRT_STEPS   = 31;
   localparam int DIV_STEPS    = 25;
   localparam int NORM_STEPS   = 6;
   localparam int NUM_LANES    = 3;

   // Datapath widths
   localparam int CW        = 48;  // CORDIC x/y
   localparam int ZW        = 28;  // angle accumulator, Q.24 radians
   localparam int SQ_N_W    = 2 * SQRT_STEPS;
   localparam int SQ_ROOT_W = SQRT_STEPS;
   localparam int SQ_REM_W  = SQRT_STEPS + 3;
   localparam int MAG_W     = DIV_STEPS;
   localparam int NORM_TOP  = 41;  // a nonzero magnitude is normalized to at least 2^40

   localparam int LANE_PAN  = 0;
   localparam int LANE_LIFT = 1;
   localparam int LANE_ELB  = 2;

   localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;

   localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
      28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
      28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
      28'sd256, 28'sd128, 28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
   };

   // Pipeline stage map
   localparam int ST_DIFF   = 0;
   localparam int ST_PROD   = ST_DIFF + 1;
   localparam int ST_SUM    = ST_PROD + 1;
   localparam int ST_ABS    = ST_SUM + 1;
   localparam int ST_SHIFT  = ST_ABS + 1;
   localparam int ST_SQR    = ST_SHIFT + 1;
   localparam int ST_CSUM   = ST_SQR + 1;
   localparam int ST_SQRT   = ST_CSUM + 1;
   localparam int ST_PREP   = ST_SQRT + SQRT_STEPS;
   localparam int ST_NORM   = ST_PREP + 1;
   localparam int ST_CORDIC = ST_NORM + NORM_STEPS;
   localparam int ST_ANGLE  = ST_CORDIC + CORDIC_STEPS;
   localparam int ST_MUL    = ST_ANGLE + 1;
   localparam int ST_DIV    = ST_MUL + 1;
   localparam int ST_ROUND  = ST_DIV + DIV_STEPS;
   localparam int ST_CHECK  = ST_ROUND + 1;
   localparam int N_STAGES  = ST_CHECK + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ARM_REACH,
      REG_PAN_LO,
      REG_PAN_HI,
      REG_LIFT_LO,
      REG_LIFT_HI,
      REG_ELB_LO,
      REG_ELB_HI,
      REG_FIXED_OK
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] shoulder_x;
      logic signed [COORD_W-1:0] shoulder_y;
      logic signed [COORD_W-1:0] shoulder_z;
      logic signed [COORD_W-1:0] elbow_x;
      logic signed [COORD_W-1:0] elbow_y;
      logic signed [COORD_W-1:0] elbow_z;
      logic signed [COORD_W-1:0] wrist_x;
      logic signed [COORD_W-1:0] wrist_y;
      logic signed [COORD_W-1:0] wrist_z;
   } pose_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] pan_angle;
      logic signed [ANG_W-1:0] lift_angle;
      logic signed [ANG_W-1:0] elb_angle;
      logic                    in_bounds;
   } angle_type;

   typedef struct packed {
      logic [REACH_W-1:0]      arm_reach;
      logic signed [ANG_W-1:0] pan_lower_limit;
      logic signed [ANG_W-1:0] pan_upper_limit;
      logic signed [ANG_W-1:0] lift_lower_limit;
      logic signed [ANG_W-1:0] lift_upper_limit;
      logic signed [ANG_W-1:0] elbow_lower_limit;
      logic signed [ANG_W-1:0] elbow_upper_limit;
      logic                    fixed_joints_valid;
   } cfg_type;

   typedef struct packed {
      logic [SQ_N_W-1:0]    n;
      logic [SQ_REM_W-1:0]  rem;
      logic [SQ_ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic [CW-1:0]        m;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } lane_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] ux, uy, uz, vx, vy, vz;
      logic                     u_zero, v_zero;
      logic [2*DIFF_W-1:0]      sq_x, sq_z;
      logic signed [2*DIFF_W-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx, p_xx, p_yy, p_zz;
      logic signed [2*DIFF_W:0]   cx, cy, cz;
      logic signed [2*DIFF_W+1:0] dot;
      logic [2*DIFF_W-1:0]      ax, ay, az;
      logic [2*DIFF_W:0]        ad;
      logic                     dot_neg;
      logic [59:0]              sqx, sqy, sqz;
      sqrt_type                 h_sq, c_sq;
      lane_type [NUM_LANES-1:0] lanes;
      logic signed [ZW-1:0]     pan_z, lift_z, elb_z;
      logic                     pan_scale, pan_neg;
      logic [MAG_W-1:0]         pan_mag;
      logic [REACH_W-1:0]       dv_rem;
      logic [DIV_STEPS-1:0]     dv_low, dv_q;
      logic signed [ANG_W-1:0]  pan_q, lift_q, elb_q;
      logic                     ok;
   } item_type;

   // One digit of the square root: two radicand bits in, one root bit out
   function automatic sqrt_type sqrt_step(input sqrt_type s);
      logic [SQ_REM_W+1:0] rw, t;
      sqrt_type r;
      rw = {s.rem, s.n[SQ_N_W-1 -: 2]};
      t  = {3'b000, s.root, 2'b01};
      r.n = {s.n[SQ_N_W-3:0], 2'b00};
      if (rw >= t) begin
         r.rem  = SQ_REM_W'(rw - t);
         r.root = {s.root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = rw[SQ_REM_W-1:0];
         r.root = {s.root[SQ_ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // Round Q.24 to Q3.16, nearest with ties up, and saturate
   function automatic logic signed [ANG_W-1:0] to_q16(input logic signed [ZW-1:0] a);
      logic signed [ZW:0] t;
      t = ($signed({a[ZW-1], a}) + 29'sd128) >>> 8;
      if (t > 29'sd524287) begin
         return 20'sd524287;
      end else if (t < -29'sd524288) begin
         return -20'sd524288;
      end
      return t[ANG_W-1:0];
   endfunction

   function automatic logic [CW-1:0] mag_cw(input logic signed [CW-1:0] v);
      return v[CW-1] ? CW'(-v) : CW'(v);
   endfunction

endpackage

// ===== rtl/core/apja_pose_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apja_pose_if
// Valid/ready channel that carries one arm pose.
// ----------------------------------------------------------------------------
interface apja_pose_if;
   import apja_pkg::*;

   logic     valid;
   logic     ready;
   pose_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/apja_angle_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apja_angle_if
// Valid/ready channel that carries one set of joint angles.
// ----------------------------------------------------------------------------
interface apja_angle_if;
   import apja_pkg::*;

   logic      valid;
   logic      ready;
   angle_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/apja_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apja_pipe
// Fully pipelined angle datapath: products, square roots, three CORDIC
// vectoring lanes, pan scaling divider, rounding and limit check.
// ----------------------------------------------------------------------------
module apja_pipe (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  apja_pkg::pose_type pose,
   input  apja_pkg::cfg_type  cfg,
   output logic               out_valid,
   output apja_pkg::angle_type out_data
);
   import apja_pkg::*;

   item_type              stage_ff [N_STAGES];
   item_type              stage_in [N_STAGES];
   logic [N_STAGES-1:0]   vld_ff;

   // Form the arm segment vectors
   always_comb begin
      item_type d;
      d = '0;
      d.ux = DIFF_W'(pose.elbow_x) - DIFF_W'(pose.shoulder_x);
      d.uy = DIFF_W'(pose.elbow_y) - DIFF_W'(pose.shoulder_y);
      d.uz = DIFF_W'(pose.elbow_z) - DIFF_W'(pose.shoulder_z);
      d.vx = DIFF_W'(pose.wrist_x) - DIFF_W'(pose.elbow_x);
      d.vy = DIFF_W'(pose.wrist_y) - DIFF_W'(pose.elbow_y);
      d.vz = DIFF_W'(pose.wrist_z) - DIFF_W'(pose.elbow_z);
      d.u_zero = (d.ux == '0) && (d.uy == '0) && (d.uz == '0);
      d.v_zero = (d.vx == '0) && (d.vy == '0) && (d.vz == '0);
      stage_in[ST_DIFF] = d;
   end

   for (genvar k = 1; k < N_STAGES; k++) begin : g_stage
      if (k == ST_PROD) begin : g_prod
         // Multiply: squares, cross and dot terms
         always_comb begin
            item_type c, nx;
            c  = stage_ff[k-1];
            nx = c;
            nx.sq_x = 42'($signed(42'($signed(c.ux))) * $signed(42'($signed(c.ux))));
            nx.sq_z = 42'($signed(42'($signed(c.uz))) * $signed(42'($signed(c.uz))));
            nx.p_yz = $signed(42'($signed(c.uy))) * $signed(42'($signed(c.vz)));
            nx.p_zy = $signed(42'($signed(c.uz))) * $signed(42'($signed(c.vy)));
            nx.p_zx = $signed(42'($signed(c.uz))) * $signed(42'($signed(c.vx)));
            nx.p_xz = $signed(42'($signed(c.ux))) * $signed(42'($signed(c.vz)));
            nx.p_xy = $signed(42'($signed(c.ux))) * $signed(42'($signed(c.vy)));
            nx.p_yx = $signed(42'($signed(c.uy))) * $signed(42'($signed(c.vx)));
            nx.p_xx = $signed(42'($signed(c.ux))) * $signed(42'($signed(c.vx)));
            nx.p_yy = $signed(42'($signed(c.uy))) * $signed(42'($signed(c.vy)));
            nx.p_zz = $signed(42'($signed(c.uz))) * $signed(42'($signed(c.vz)));
            stage_in[k] = nx;
         end
      end else if (k == ST_SUM) begin : g_sum
         // Add up the cross and dot terms, load the horizontal root
         always_comb begin
            item_type c, nx;
            c  = stage_ff[k-1];
            nx = c;
            nx.h_sq.n    = SQ_N_W'(c.sq_x) + SQ_N_W'(c.sq_z);
            nx.h_sq.rem  = '0;
            nx.h_sq.root = '0;
            nx.cx  = $signed(43'($signed(c.p_yz))) - $signed(43'($signed(c.p_zy)));
            nx.cy  = $signed(43'($signed(c.p_zx))) - $signed(43'($signed(c.p_xz)));
            nx.cz  = $signed(43'($signed(c.p_xy))) - $signed(43'($signed(c.p_yx)));
            nx.dot = $signed(44'($signed(c.p_xx))) + $signed(44'($signed(c.p_yy)))
                   + $signed(44'($signed(c.p_zz)));
            stage_in[k] = nx;
         end
      end else if (k == ST_ABS) begin : g_abs
         // Take magnitudes, keep the dot sign
         always_comb begin
            item_type c, nx;
            c  = stage_ff[k-1];
            nx = c;
            nx.ax      = 42'(c.cx[42] ? -c.cx : c.cx);
            nx.ay      = 42'(c.cy[42] ? -c.cy : c.cy);
            nx.az      = 42'(c.cz[42] ? -c.cz : c.cz);
            nx.ad      = 43'(c.dot[43] ? -c.dot : c.dot);
            nx.dot_neg = c.dot[43];
            stage_in[k] = nx;
         end
      end else if (k == ST_SHIFT) begin : g_shift
         // Scale cross and dot down until every cross term is below 2^30
         always_comb begin
            item_type c, nx;
            logic [2*DIFF_W-1:0] orv;
            logic [3:0] sel;
            c   = stage_ff[k-1];
            nx  = c;
            orv = c.ax | c.ay | c.az;
            sel = 4'd0;
            for (int s = 12; s >= 0; s--) begin
               if ((orv >> s) < 42'h0_4000_0000) begin
                  sel = 4'(s);
               end
            end
            nx.ax = c.ax >> sel;
            nx.ay = c.ay >> sel;
            nx.az = c.az >> sel;
            nx.ad = c.ad >> sel;
            stage_in[k] = nx;
         end
      end else if (k == ST_SQR) begin : g_sqr
         always_comb begin
            item_type c, nx;
            c  = stage_ff[k-1];
            nx = c;
            nx.sqx = c.ax[29:0] * c.ax[29:0];
            nx.sqy = c.ay[29:0] * c.ay[29:0];
            nx.sqz = c.az[29:0] * c.az[29:0];
            stage_in[k] = nx;
         end
      end else if (k == ST_CSUM) begin : g_csum
         // Load the cross-length root
         always_comb begin
            item_type c, nx;
            c  = stage_ff[k-1];
            nx = c;
            nx.c_sq.n    = SQ_N_W'(c.sqx) + SQ_N_W'(c.sqy) + SQ_N_W'(c.sqz);
            nx.c_sq.rem  = '0;
            nx.c_sq.root = '0;
            stage_in[k] = nx;
         end
      end else if (k >= ST_SQRT && k < ST_PREP) begin : g_sqrt
         always_comb begin
            item_type nx;
            nx = stage_ff[k-1];
            nx.h_sq = sqrt_step(stage_ff[k-1].h_sq);
            nx.c_sq = sqrt_step(stage_ff[k-1].c_sq);
            stage_in[k] = nx;
         end
      end else if (k == ST_PREP) begin : g_prep
         // Set up the three vectoring lanes, rotate a left half-plane elbow
         always_comb begin
            item_type c, nx;
            logic signed [DIFF_W-1:0] aux;
            logic [CW-1:0] mx, my;
            c   = stage_ff[k-1];
            nx  = c;
            aux = c.ux[DIFF_W-1] ? -c.ux : c.ux;
            nx.lanes[LANE_PAN].x    = CW'($signed(aux));
            nx.lanes[LANE_PAN].y    = -CW'($signed(c.uz));
            nx.lanes[LANE_PAN].z    = '0;
            nx.lanes[LANE_PAN].zero = (c.ux == '0) && (c.uz == '0);
            nx.lanes[LANE_LIFT].x    = CW'(c.h_sq.root);
            nx.lanes[LANE_LIFT].y    = CW'($signed(c.uy));
            nx.lanes[LANE_LIFT].z    = '0;
            nx.lanes[LANE_LIFT].zero = (c.h_sq.root == '0) && (c.uy == '0);
            if (c.dot_neg && (c.ad != '0)) begin
               nx.lanes[LANE_ELB].x = CW'(c.c_sq.root);
               nx.lanes[LANE_ELB].y = CW'(c.ad);
               nx.lanes[LANE_ELB].z = HALF_PI_Q24;
            end else begin
               nx.lanes[LANE_ELB].x = CW'(c.ad);
               nx.lanes[LANE_ELB].y = CW'(c.c_sq.root);
               nx.lanes[LANE_ELB].z = '0;
            end
            nx.lanes[LANE_ELB].zero = (c.c_sq.root == '0) && (c.ad == '0);
            for (int l = 0; l < NUM_LANES; l++) begin
               mx = mag_cw(nx.lanes[l].x);
               my = mag_cw(nx.lanes[l].y);
               nx.lanes[l].m = (mx > my) ? mx : my;
            end
            stage_in[k] = nx;
         end
      end else if (k >= ST_NORM && k < ST_CORDIC) begin : g_norm
         // Normalize: shift up by a halving step while below the target range
         localparam int SH = 32 >> (k - ST_NORM);
         always_comb begin
            item_type c, nx;
            c  = stage_ff[k-1];
            nx = c;
            for (int l = 0; l < NUM_LANES; l++) begin
               if (c.lanes[l].m < (CW'(1) << (NORM_TOP - SH))) begin
                  nx.lanes[l].x = c.lanes[l].x <<< SH;
                  nx.lanes[l].y = c.lanes[l].y <<< SH;
                  nx.lanes[l].m = c.lanes[l].m << SH;
               end
            end
            stage_in[k] = nx;
         end
      end else if (k >= ST_CORDIC && k < ST_ANGLE) begin : g_cordic
         // One vectoring rotation per lane
         localparam int I = k - ST_CORDIC;
         always_comb begin
            item_type c, nx;
            logic signed [CW-1:0] x0, y0, xs, ys;
            c  = stage_ff[k-1];
            nx = c;
            for (int l = 0; l < NUM_LANES; l++) begin
               x0 = c.lanes[l].x;
               y0 = c.lanes[l].y;
               xs = x0 >>> I;
               ys = y0 >>> I;
               if (!y0[CW-1]) begin
                  nx.lanes[l].x = x0 + ys;
                  nx.lanes[l].y = y0 - xs;
                  nx.lanes[l].z = $signed(c.lanes[l].z) + ATAN_TAB[I];
               end else begin
                  nx.lanes[l].x = x0 - ys;
                  nx.lanes[l].y = y0 + xs;
                  nx.lanes[l].z = $signed(c.lanes[l].z) - ATAN_TAB[I];
               end
            end
            stage_in[k] = nx;
         end
      end else if (k == ST_ANGLE) begin : g_angle
         // Resolve special cases, decide on pan scaling
         always_comb begin
            item_type c, nx;
            logic signed [ZW-1:0] pz;
            c  = stage_ff[k-1];
            nx = c;
            pz = c.lanes[LANE_PAN].zero ? '0 : c.lanes[LANE_PAN].z;
            nx.pan_z  = pz;
            nx.lift_z = (c.lanes[LANE_LIFT].zero ? '0 : $signed(c.lanes[LANE_LIFT].z))
                      - HALF_PI_Q24;
            if (c.u_zero || c.v_zero) begin
               nx.elb_z = HALF_PI_Q24;
            end else begin
               nx.elb_z = c.lanes[LANE_ELB].zero ? '0 : c.lanes[LANE_ELB].z;
            end
            nx.pan_scale = c.h_sq.root < SQ_ROOT_W'(cfg.arm_reach);
            nx.pan_neg   = pz[ZW-1];
            nx.pan_mag   = MAG_W'(pz[ZW-1] ? -pz : pz);
            stage_in[k] = nx;
         end
      end else if (k == ST_MUL) begin : g_mul
         // Multiply pan magnitude by horizontal length, load the divider
         always_comb begin
            item_type c, nx;
            logic [MAG_W+REACH_W-1:0] prod;
            c    = stage_ff[k-1];
            nx   = c;
            prod = c.pan_mag * c.h_sq.root[REACH_W-1:0];
            nx.dv_rem = prod[MAG_W+REACH_W-1:DIV_STEPS];
            nx.dv_low = prod[DIV_STEPS-1:0];
            nx.dv_q   = '0;
            stage_in[k] = nx;
         end
      end else if (k >= ST_DIV && k < ST_ROUND) begin : g_div
         // One restoring division step by the reach
         always_comb begin
            item_type c, nx;
            logic [REACH_W:0] rw;
            c  = stage_ff[k-1];
            nx = c;
            rw = {c.dv_rem, c.dv_low[DIV_STEPS-1]};
            nx.dv_low = {c.dv_low[DIV_STEPS-2:0], 1'b0};
            if (rw >= {1'b0, cfg.arm_reach}) begin
               nx.dv_rem = REACH_W'(rw - {1'b0, cfg.arm_reach});
               nx.dv_q   = {c.dv_q[DIV_STEPS-2:0], 1'b1};
            end else begin
               nx.dv_rem = rw[REACH_W-1:0];
               nx.dv_q   = {c.dv_q[DIV_STEPS-2:0], 1'b0};
            end
            stage_in[k] = nx;
         end
      end else if (k == ST_ROUND) begin : g_round
         always_comb begin
            item_type c, nx;
            logic signed [ZW-1:0] qz, pf;
            c  = stage_ff[k-1];
            nx = c;
            qz = $signed({{(ZW-DIV_STEPS){1'b0}}, c.dv_q});
            if (c.pan_scale) begin
               pf = c.pan_neg ? -qz : qz;
            end else begin
               pf = c.pan_z;
            end
            nx.pan_q  = to_q16(pf);
            nx.lift_q = to_q16(c.lift_z);
            nx.elb_q  = to_q16(c.elb_z);
            stage_in[k] = nx;
         end
      end else begin : g_check
         // Compare each angle with its limits
         always_comb begin
            item_type c, nx;
            c  = stage_ff[k-1];
            nx = c;
            nx.ok = cfg.fixed_joints_valid
               && ($signed(c.pan_q) >= $signed(cfg.pan_lower_limit))
               && ($signed(c.pan_q) <= $signed(cfg.pan_upper_limit))
               && ($signed(c.lift_q) >= $signed(cfg.lift_lower_limit))
               && ($signed(c.lift_q) <= $signed(cfg.lift_upper_limit))
               && ($signed(c.elb_q) >= $signed(cfg.elbow_lower_limit))
               && ($signed(c.elb_q) <= $signed(cfg.elbow_upper_limit));
            stage_in[k] = nx;
         end
      end
   end

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N_STAGES-2:0], in_valid};
      end
   end

   // Advance payload, hold on stall
   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid            = vld_ff[N_STAGES-1];
   assign out_data.pan_angle   = stage_ff[N_STAGES-1].pan_q;
   assign out_data.lift_angle  = stage_ff[N_STAGES-1].lift_q;
   assign out_data.elb_angle   = stage_ff[N_STAGES-1].elb_q;
   assign out_data.in_bounds   = stage_ff[N_STAGES-1].ok;

endmodule

// ===== rtl/core/arm_pose_to_joint_angles.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_pose_to_joint_angles
// Shoulder, elbow and wrist positions in, pan, lift and elbow angles out.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries one pose (nine Q3.16 coordinates) per valid/ready transfer;
//    rsp_ch returns one result per pose, in order: three Q3.16 angles and an
//    in-bounds flag.
//  - csr_we/csr_index/csr_wdata write the reach, the joint limits and the
//    fixed-joint flag; write them only while no pose is in flight.
//  - Throughput is one pose per cycle while the output buffer has room. Every
//    square root digit, CORDIC rotation and divider step has a register stage
//    of its own (98 stages); a result passes them all and then the output
//    buffer before it is offered on rsp_ch.
//  - A two-entry output buffer parts the pipeline from the receiver: while
//    one result waits, the pipeline keeps moving and keeps taking poses; only
//    with both entries full does req_ch.ready drop and the whole pipeline
//    hold.
//  - Reset empties the pipeline and the buffer and loads the default limits.
// ----------------------------------------------------------------------------
module arm_pose_to_joint_angles (
   input  logic                             clock,
   input  logic                             reset,
   apja_pose_if.sink                        req_ch,
   apja_angle_if.source                     rsp_ch,
   input  logic                             csr_we,
   input  logic [apja_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [apja_pkg::CSR_W-1:0]       csr_wdata
);
   import apja_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      en;
   logic      core_valid;
   angle_type core_data;
   logic [1:0] count_ff, count_in;
   angle_type buf0_ff, buf0_in, buf1_ff, buf1_in;
   logic      push, pop;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_ARM_REACH: cfg_in.arm_reach          = csr_wdata[REACH_W-1:0];
            REG_PAN_LO:    cfg_in.pan_lower_limit    = csr_wdata[ANG_W-1:0];
            REG_PAN_HI:    cfg_in.pan_upper_limit    = csr_wdata[ANG_W-1:0];
            REG_LIFT_LO:   cfg_in.lift_lower_limit   = csr_wdata[ANG_W-1:0];
            REG_LIFT_HI:   cfg_in.lift_upper_limit   = csr_wdata[ANG_W-1:0];
            REG_ELB_LO:    cfg_in.elbow_lower_limit  = csr_wdata[ANG_W-1:0];
            REG_ELB_HI:    cfg_in.elbow_upper_limit  = csr_wdata[ANG_W-1:0];
            REG_FIXED_OK:  cfg_in.fixed_joints_valid = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.arm_reach          <= 19'd19661;
         cfg_ff.pan_lower_limit    <= -20'sd411775;
         cfg_ff.pan_upper_limit    <= 20'sd411775;
         cfg_ff.lift_lower_limit   <= -20'sd411775;
         cfg_ff.lift_upper_limit   <= 20'sd411775;
         cfg_ff.elbow_lower_limit  <= -20'sd205887;
         cfg_ff.elbow_upper_limit  <= 20'sd205887;
         cfg_ff.fixed_joints_valid <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Hold the pipeline only when the output buffer is full
   assign en           = (count_ff != 2'd2);
   assign req_ch.ready = en;

   apja_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .pose      (req_ch.data),
      .cfg       (cfg_ff),
      .out_valid (core_valid),
      .out_data  (core_data)
   );

   // Two-entry output buffer
   assign push          = en && core_valid;
   assign rsp_ch.valid  = (count_ff != 2'd0);
   assign rsp_ch.data   = buf0_ff;
   assign pop           = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      buf0_in  = buf0_ff;
      buf1_in  = buf1_ff;
      count_in = count_ff;
      if (pop) begin
         buf0_in = buf1_ff;
      end
      if (push) begin
         if ((count_ff == 2'd0) || ((count_ff == 2'd1) && pop)) begin
            buf0_in = core_data;
         end else begin
            buf1_in = core_data;
         end
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      buf0_ff <= buf0_in;
      buf1_ff <= buf1_in;
   end

endmodule

// ===== verif/arm_pose_to_joint_angles_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_pose_to_joint_angles_test
// Self-checking bench for the pose-to-joint-angle pipeline. Poses go in on
// bursts with random gaps, the result side stalls on its own pattern, and a
// bit-exact angle predictor checks every result in order. Several register
// settings are applied between phases, extremes included.
// ----------------------------------------------------------------------------
module arm_pose_to_joint_angles_test;
   import apja_pkg::*;

   localparam time CYCLE      = 20ns;
   localparam int  SETTLE     = 120;   // pipeline depth plus margin
   localparam int  PHASE_ITEMS = 210;

   // Predict joint angles from a pose and hold the results still due
   class angle_scoreboard;
      angle_type        expected_q[$];
      longint unsigned  reach;
      longint           lim_lo[3];
      longint           lim_hi[3];
      bit               fixed_ok;
      int               errors;

      function new();
         errors = 0;
         reset_regs();
      endfunction

      function void reset_regs();
         reach     = 19661;
         lim_lo[0] = -411775; lim_hi[0] = 411775;
         lim_lo[1] = -411775; lim_hi[1] = 411775;
         lim_lo[2] = -205887; lim_hi[2] = 205887;
         fixed_ok  = 1'b1;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_W-1:0] v);
         case (idx)
            REG_ARM_REACH: reach     = v[REACH_W-1:0];
            REG_PAN_LO:    lim_lo[0] = longint'($signed(v));
            REG_PAN_HI:    lim_hi[0] = longint'($signed(v));
            REG_LIFT_LO:   lim_lo[1] = longint'($signed(v));
            REG_LIFT_HI:   lim_hi[1] = longint'($signed(v));
            REG_ELB_LO:    lim_lo[2] = longint'($signed(v));
            REG_ELB_HI:    lim_hi[2] = longint'($signed(v));
            REG_FIXED_OK:  fixed_ok  = v[0];
            default: ;
         endcase
      endfunction

      function longint unsigned magnitude(longint v);
         return (v < 0) ? longint'(-v) : v;
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      // Vectoring CORDIC, Q.24 radians
      function longint vector_angle(longint y, longint x);
         longint z, t, xs, ys;
         longint unsigned m;
         z = 0;
         if (x == 0 && y == 0) return 0;
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; z = HALF_PI_Q24;
            end else begin
               t = x; x = -y; y = t; z = -longint'(HALF_PI_Q24);
            end
         end
         m = (magnitude(x) > magnitude(y)) ? magnitude(x) : magnitude(y);
         while (m < (64'd1 << 40)) begin
            x = x * 2; y = y * 2; m = m * 2;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
            end else begin
               x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
            end
         end
         return z;
      endfunction

      // Round to nearest with ties up, then saturate to the field
      function longint round_angle(longint a);
         longint r;
         r = (a + 128) >>> 8;
         if (r > 524287) r = 524287;
         if (r < -524288) r = -524288;
         return r;
      endfunction

      function angle_type predict_angles(pose_type p);
         longint ux, uy, uz, vx, vy, vz, cx, cy, cz, dotp;
         longint pan, lift, elb, pq, lq, eq;
         longint unsigned h, pm, ax, ay, az, ad, cm;
         int s;
         angle_type r;
         ux = longint'(p.elbow_x) - longint'(p.shoulder_x);
         uy = longint'(p.elbow_y) - longint'(p.shoulder_y);
         uz = longint'(p.elbow_z) - longint'(p.shoulder_z);
         vx = longint'(p.wrist_x) - longint'(p.elbow_x);
         vy = longint'(p.wrist_y) - longint'(p.elbow_y);
         vz = longint'(p.wrist_z) - longint'(p.elbow_z);
         h = int_sqrt(ux * ux + uz * uz);

         // Pan, folded and scaled down inside the reach
         pan = vector_angle(-uz, magnitude(ux));
         if (h < reach) begin
            pm  = magnitude(pan) * h / reach;
            pan = (pan < 0) ? -longint'(pm) : longint'(pm);
         end

         lift = vector_angle(uy, longint'(h)) - longint'(HALF_PI_Q24);

         // Elbow: right angle when either segment has no length
         if ((ux == 0 && uy == 0 && uz == 0) || (vx == 0 && vy == 0 && vz == 0)) begin
            elb = HALF_PI_Q24;
         end else begin
            cx = uy * vz - uz * vy;
            cy = uz * vx - ux * vz;
            cz = ux * vy - uy * vx;
            dotp = ux * vx + uy * vy + uz * vz;
            ax = magnitude(cx); ay = magnitude(cy); az = magnitude(cz);
            ad = magnitude(dotp);
            s = 0;
            while ((ax >> s) >= (64'd1 << 30) || (ay >> s) >= (64'd1 << 30) ||
                   (az >> s) >= (64'd1 << 30))
               s++;
            ax >>= s; ay >>= s; az >>= s; ad >>= s;
            cm  = int_sqrt(ax * ax + ay * ay + az * az);
            elb = vector_angle(longint'(cm), (dotp < 0) ? -longint'(ad) : longint'(ad));
         end

         pq = round_angle(pan);
         lq = round_angle(lift);
         eq = round_angle(elb);
         r.pan_angle   = pq[ANG_W-1:0];
         r.lift_angle  = lq[ANG_W-1:0];
         r.elb_angle   = eq[ANG_W-1:0];
         r.in_bounds   = fixed_ok && pq >= lim_lo[0] && pq <= lim_hi[0] &&
                         lq >= lim_lo[1] && lq <= lim_hi[1] &&
                         eq >= lim_lo[2] && eq <= lim_hi[2];
         return r;
      endfunction

      function void note_pose(pose_type p);
         expected_q = {expected_q, predict_angles(p)};
      endfunction

      function void check_angles(angle_type got);
         angle_type exp_a;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
         end
         exp_a = expected_q.pop_front();
         if (got !== exp_a) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch at %0t:", $realtime);
               $display("  pan   exp %0d got %0d", exp_a.pan_angle, got.pan_angle);
               $display("  lift  exp %0d got %0d", exp_a.lift_angle, got.lift_angle);
               $display("  elbow exp %0d got %0d", exp_a.elb_angle, got.elb_angle);
               $display("  flag  exp %0b got %0b", exp_a.in_bounds, got.in_bounds);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   apja_pose_if  pose_ch ();
   apja_angle_if angle_ch ();

   arm_pose_to_joint_angles u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (pose_ch.sink),
      .rsp_ch    (angle_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   angle_scoreboard sb = new();
   int  burst_left = 0;
   bit  hold_request = 0;

   // Clock
   initial clock = 1'b0;
   always #(CYCLE / 2) clock = ~clock;

   // Timeout guard
   initial begin
      #(CYCLE * 1_000_000);
      $display("Some tests failed");
      $finish;
   end

   // Receive results: check every transfer, stall on a randomly chosen pattern
   initial begin
      int hold_left, cyc, mode;
      hold_left = 0;
      cyc = 0;
      angle_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && angle_ch.valid && angle_ch.ready) sb.check_angles(angle_ch.data);
         if (hold_request) begin
            hold_left = 400;
            hold_request = 0;
         end
         cyc++;
         if (cyc % 100 == 0) mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            angle_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0: angle_ch.ready <= 1'b1;
               1: angle_ch.ready <= ($urandom_range(0, 3) != 0);
               2: angle_ch.ready <= ($urandom_range(0, 9) < 4);
               default: angle_ch.ready <= ((cyc % 7) >= 3);
            endcase
         end
      end
   end

   // Offer one pose and hold it until transferred; gap at burst ends
   task automatic send_pose(input pose_type p);
      pose_ch.valid <= 1'b1;
      pose_ch.data  <= p;
      do @(posedge clock); while (!pose_ch.ready);
      sb.note_pose(p);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         pose_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 20);
      end
   endtask

   function automatic pose_type mk(int sx, int sy, int sz, int ex, int ey, int ez,
                                   int wx, int wy, int wz);
      pose_type p;
      p.shoulder_x = sx[COORD_W-1:0]; p.shoulder_y = sy[COORD_W-1:0];
      p.shoulder_z = sz[COORD_W-1:0];
      p.elbow_x    = ex[COORD_W-1:0]; p.elbow_y    = ey[COORD_W-1:0];
      p.elbow_z    = ez[COORD_W-1:0];
      p.wrist_x    = wx[COORD_W-1:0]; p.wrist_y    = wy[COORD_W-1:0];
      p.wrist_z    = wz[COORD_W-1:0];
      return p;
   endfunction

   function automatic int pick_extreme();
      case ($urandom_range(0, 4))
         0: return -524288;
         1: return 524287;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   function automatic int offset(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   // Build a random pose: arm-like (degenerate shapes included) half the time, else noise or extremes
   function automatic pose_type random_pose();
      pose_type p;
      logic [191:0] raw_bits;
      int k;
      k = $urandom_range(0, 9);
      raw_bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p = raw_bits[$bits(pose_type)-1:0];
      if (k >= 4 && k <= 8) begin
         p.shoulder_x = COORD_W'(offset(1 << 18));
         p.shoulder_y = COORD_W'(offset(1 << 18));
         p.shoulder_z = COORD_W'(offset(1 << 18));
         p.elbow_x = COORD_W'(p.shoulder_x + offset(1 << 16));
         p.elbow_y = COORD_W'(p.shoulder_y + offset(1 << 16));
         p.elbow_z = COORD_W'(p.shoulder_z + offset(1 << 16));
         p.wrist_x = COORD_W'(p.elbow_x + offset(1 << 16));
         p.wrist_y = COORD_W'(p.elbow_y + offset(1 << 16));
         p.wrist_z = COORD_W'(p.elbow_z + offset(1 << 16));
         if (k == 7) begin
            if ($urandom_range(0, 1)) begin
               p.elbow_x = p.shoulder_x; p.elbow_y = p.shoulder_y;
               p.elbow_z = p.shoulder_z;
            end else begin
               p.wrist_x = p.elbow_x; p.wrist_y = p.elbow_y; p.wrist_z = p.elbow_z;
            end
         end else if (k == 8) begin
            p.elbow_x = p.shoulder_x;
            p.elbow_z = p.shoulder_z;
         end
      end else if (k == 9) begin
         p = mk(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                pick_extreme());
      end
      return p;
   endfunction

   // Lower valid, let every result arrive, then let the pipeline settle
   task automatic drain();
      pose_ch.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic write_all(input int reach, input int pl, input int ph, input int ll,
                            input int lh, input int el, input int eh, input bit ok);
      write_reg(REG_ARM_REACH, reach[CSR_W-1:0]);
      write_reg(REG_PAN_LO, pl[CSR_W-1:0]);
      write_reg(REG_PAN_HI, ph[CSR_W-1:0]);
      write_reg(REG_LIFT_LO, ll[CSR_W-1:0]);
      write_reg(REG_LIFT_HI, lh[CSR_W-1:0]);
      write_reg(REG_ELB_LO, el[CSR_W-1:0]);
      write_reg(REG_ELB_HI, eh[CSR_W-1:0]);
      write_reg(REG_FIXED_OK, {19'd0, ok});
   endtask

   task automatic write_random_config();
      write_all($urandom_range(1, 524287), -$urandom_range(0, 300000),
                $urandom_range(0, 300000), -$urandom_range(0, 300000),
                $urandom_range(0, 300000), -$urandom_range(0, 300000),
                $urandom_range(0, 300000), $urandom_range(0, 3) != 0);
   endtask

   task automatic random_phase(input int n);
      repeat (n) send_pose(random_pose());
   endtask

   // Main sequence
   initial begin
      pose_ch.valid <= 1'b0;
      pose_ch.data  <= '0;
      csr_we        <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      reset         <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed poses under reset settings
      send_pose(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pose(mk(1000, 2000, 3000, 1000, 2000, 3000, 5000, 0, 0));
      send_pose(mk(0, 0, 0, 20000, -10000, 5000, 20000, -10000, 5000));
      send_pose(mk(0, 0, 0, 0, 30000, 0, 30000, 30000, 0));
      send_pose(mk(0, 0, 0, 0, -30000, 0, 0, -30000, 40000));
      send_pose(mk(0, 0, 0, -30000, 0, 10000, -60000, 0, 10000));
      send_pose(mk(0, 0, 0, -30000, 5000, -10000, -30000, 60000, -10000));
      send_pose(mk(-524288, -524288, -524288, 524287, 524287, 524287,
                   -524288, -524288, -524288));
      send_pose(mk(524287, -524288, 524287, -524288, 524287, -524288,
                   524287, 524287, -524288));
      send_pose(mk(-524288, 0, 524287, 524287, -524288, -524288, 0, 524287, 524287));
      send_pose(mk(0, 0, 0, 65536, 0, 0, 65536, 65536, 0));
      send_pose(mk(0, 0, 0, 65536, 0, 0, 131072, 0, 0));
      send_pose(mk(0, 0, 0, 65536, 0, 0, 0, 0, 0));
      send_pose(mk(0, 0, 0, 100, 0, -100, 200, 50, -100));
      send_pose(mk(0, 0, 0, 19661, 0, 0, 19661, 19661, 0));
      send_pose(mk(0, 0, 0, 0, 0, -65536, 0, 0, 0));
      send_pose(mk(0, 0, 0, 0, 0, 65536, 1, 1, 65536));
      send_pose(mk(524287, 524287, 524287, 524287, 524287, 524287,
                   524287, 524287, 524287));
      send_pose(mk(-1, -1, -1, 0, 0, 0, 1, -1, 1));
      send_pose(mk(0, 0, 0, 3, -2, 1, 6, -4, 2));
      random_phase(PHASE_ITEMS);
      drain();

      // Zero reach, widest limits
      write_all(0, -524288, 524287, -524288, 524287, -524288, 524287, 1'b1);
      random_phase(PHASE_ITEMS);
      drain();

      // Largest reach, narrow limits, fixed joints out of range
      write_all(524287, -20000, 20000, -150000, -50000, 0, 100000, 1'b0);
      random_phase(PHASE_ITEMS);
      drain();

      // Smallest reach, crossed pan limits
      write_all(1, 524287, -524288, -524288, 524287, -524288, 524287, 1'b1);
      random_phase(PHASE_ITEMS);
      drain();

      // Long receiver hold-off while poses keep coming
      write_random_config();
      burst_left = 500;
      hold_request = 1;
      random_phase(PHASE_ITEMS);
      drain();

      // Back to reset values, then one random setting
      write_all(19661, -411775, 411775, -411775, 411775, -205887, 205887, 1'b1);
      random_phase(PHASE_ITEMS / 2);
      drain();
      write_random_config();
      random_phase(PHASE_ITEMS / 2);
      drain();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
